### rtl/bitmap_page_allocator_defines.svh
// Assertion macros for the bitmap page allocator.
// Used by rtl/bpa_datapath.sv; no other dependencies.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BPA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpa assertion failed");
// next-cycle implication
`define BPA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpa assertion failed");
`else
`define BPA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BPA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
// No dependencies.
package bpa_pkg;

   localparam int unsigned DEF_MAP_BYTES = 512;
   localparam int unsigned WORD_BITS     = 64;
   localparam int unsigned BIT_AW        = 6;
   localparam int unsigned KIND_W        = 2;
   localparam int unsigned PAGE_IDX_W    = 16;
   localparam int unsigned GRANT_W       = 12;

   localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEALLOC = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_SCAN,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic take;      // capture request fields
      logic rd;        // read the word the request targets
      logic upd;       // evaluate request, write map, update count/hint
      logic scan;      // issue next rescan read, check previous word
      logic clr;       // clear one map word after reset
      logic out_load;  // move result into output register
   } bpa_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic need_scan;
      logic scan_found;
   } bpa_status_type;

endpackage

### rtl/bpa_ctrl.sv
// Sequencing state machine for the bitmap page allocator.
// Depends on bpa_pkg.
module bpa_ctrl
   import bpa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  bpa_status_type status,
   output bpa_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.upd  = 1'b1;
            state_in = status.need_scan ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_found) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)          rsp_valid_in = 1'b1;
      else if (!rsp_stall)       rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/bpa_datapath.sv
// Map memory, count, hint and result registers of the bitmap page allocator.
// Depends on bpa_pkg and bitmap_page_allocator_defines.svh.
`include "bitmap_page_allocator_defines.svh"
module bpa_datapath
   import bpa_pkg::*;
#(
   parameter int unsigned MAP_BYTES = DEF_MAP_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bpa_cmd_type           cmd,
   output bpa_status_type        status,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [PAGE_IDX_W-1:0] req_page_index,
   output logic                  rsp_ok,
   output logic [GRANT_W-1:0]    rsp_granted_page
);

   localparam int unsigned PAGE_COUNT = MAP_BYTES * 8;
   localparam int unsigned WORDS      = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned WORD_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned EXT_W      = WORD_AW + BIT_AW;
   localparam int unsigned PAGE_AW    = $clog2(PAGE_COUNT);
   localparam int unsigned CNT_W      = $clog2(PAGE_COUNT + 1);

   logic [WORD_BITS-1:0]  mem [WORDS];
   logic [WORD_BITS-1:0]  rd_data_ff;

   logic [KIND_W-1:0]     kind_ff;
   logic [PAGE_IDX_W-1:0] page_ff;
   logic [CNT_W-1:0]      used_ff, used_in;
   logic [PAGE_AW-1:0]    hint_ff, hint_in;
   logic [WORD_AW-1:0]    scan_addr_ff, scan_addr_in;
   logic [WORD_AW-1:0]    scan_word_ff;
   logic                  scan_vld_ff, scan_vld_in;
   logic                  res_ok_ff, res_ok_in;
   logic [GRANT_W-1:0]    res_page_ff, res_page_in;
   logic                  rsp_ok_ff;
   logic [GRANT_W-1:0]    rsp_page_ff;

   logic                  in_range, tgt_bit, not_full, is_full, fills_map;
   logic [EXT_W-1:0]      tgt_ext;
   logic [WORD_AW-1:0]    tgt_word;
   logic [BIT_AW-1:0]     tgt_idx, zero_idx;
   logic [WORD_BITS-1:0]  tgt_mask;
   logic                  wr_en;
   logic [WORD_AW-1:0]    wr_addr;
   logic [WORD_BITS-1:0]  wr_data;
   logic                  rd_en;
   logic [WORD_AW-1:0]    rd_addr;
   logic                  do_alloc, do_dealloc;

   // target page: the hint for allocate, the request page otherwise
   always_comb begin
      in_range  = {16'd0, page_ff} < 32'(PAGE_COUNT);
      not_full  = used_ff < CNT_W'(PAGE_COUNT);
      is_full   = used_ff == CNT_W'(PAGE_COUNT);
      fills_map = used_ff == CNT_W'(PAGE_COUNT - 1);
      if (kind_ff == KIND_ALLOC) tgt_ext = EXT_W'(hint_ff);
      else                       tgt_ext = EXT_W'(page_ff);
      tgt_word = tgt_ext[EXT_W-1:BIT_AW];
      tgt_idx  = tgt_ext[BIT_AW-1:0];
      if (kind_ff != KIND_ALLOC && !in_range) tgt_word = '0;
      tgt_mask = WORD_BITS'(1) << tgt_idx;
      tgt_bit  = rd_data_ff[tgt_idx];
   end

   // lowest free bit of the word under scan
   always_comb begin
      zero_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!rd_data_ff[i]) zero_idx = BIT_AW'(i);
      end
   end

   always_comb begin
      do_alloc   = cmd.upd && kind_ff == KIND_ALLOC && not_full;
      do_dealloc = cmd.upd && kind_ff == KIND_DEALLOC && in_range && tgt_bit;

      status.clr_last   = scan_addr_ff == WORD_AW'(WORDS - 1);
      status.need_scan  = do_alloc && !fills_map;
      status.scan_found = scan_vld_ff && !(&rd_data_ff);

      used_in      = used_ff;
      hint_in      = hint_ff;
      res_ok_in    = res_ok_ff;
      res_page_in  = res_page_ff;
      scan_addr_in = scan_addr_ff;
      scan_vld_in  = scan_vld_ff;

      if (cmd.upd) begin
         res_ok_in   = 1'b0;
         res_page_in = '0;
         case (kind_ff)
            KIND_ALLOC: begin
               if (not_full) begin
                  res_ok_in   = 1'b1;
                  res_page_in = GRANT_W'(hint_ff);
                  used_in     = used_ff + CNT_W'(1);
               end
            end
            KIND_DEALLOC: begin
               if (do_dealloc) begin
                  res_ok_in = 1'b1;
                  if (is_full) hint_in = PAGE_AW'(page_ff);
                  if (used_ff != '0) used_in = used_ff - CNT_W'(1);
               end
            end
            KIND_QUERY: res_ok_in = in_range && !tgt_bit;
            default:    res_ok_in = 1'b0;
         endcase
         // rescan restarts at word 0
         scan_addr_in = '0;
         scan_vld_in  = 1'b0;
      end

      if (cmd.clr || cmd.scan) begin
         if (scan_addr_ff != WORD_AW'(WORDS - 1)) scan_addr_in = scan_addr_ff + WORD_AW'(1);
      end
      if (cmd.scan) begin
         scan_vld_in = 1'b1;
         if (status.scan_found) hint_in = PAGE_AW'({scan_word_ff, zero_idx});
      end

      wr_en   = cmd.clr || do_alloc || do_dealloc;
      wr_addr = cmd.clr ? scan_addr_ff : tgt_word;
      if (cmd.clr)       wr_data = '0;
      else if (do_alloc) wr_data = rd_data_ff | tgt_mask;
      else               wr_data = rd_data_ff & ~tgt_mask;

      rd_en   = cmd.rd || cmd.scan;
      rd_addr = cmd.scan ? scan_addr_ff : tgt_word;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         hint_ff      <= '0;
         scan_addr_ff <= '0;
         scan_vld_ff  <= 1'b0;
      end else begin
         used_ff      <= used_in;
         hint_ff      <= hint_in;
         scan_addr_ff <= scan_addr_in;
         scan_vld_ff  <= scan_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         kind_ff <= req_kind;
         page_ff <= req_page_index;
      end
      if (cmd.scan) scan_word_ff <= scan_addr_ff;
      res_ok_ff   <= res_ok_in;
      res_page_ff <= res_page_in;
      if (cmd.out_load) begin
         rsp_ok_ff   <= res_ok_ff;
         rsp_page_ff <= res_page_ff;
      end
   end

   assign rsp_ok           = rsp_ok_ff;
   assign rsp_granted_page = rsp_page_ff;

   // count must be nonzero on a free and never exceed the page count
   `BPA_ASSERT_IMP(a_dealloc_count, clock, reset, do_dealloc, used_ff != '0)
   `BPA_ASSERT_IMP(a_count_range, clock, reset, 1'b1, used_ff <= CNT_W'(PAGE_COUNT))
   // a rescan must stay inside the map
   `BPA_ASSERT_IMP(a_scan_bound, clock, reset, cmd.scan && scan_vld_ff,
                   32'(scan_word_ff) < WORDS)
   `BPA_ASSERT_NXT(a_alloc_marks, clock, reset, do_alloc, used_ff != '0)

endmodule

### rtl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: controller plus datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------------
//   req      | in        | req_valid/req_stall| req_kind, req_page_index
//   rsp      | out       | rsp_valid/rsp_stall| rsp_ok, rsp_granted_page
//
// One transaction at a time. For query, deallocate and any failing request the
// request is taken, its map word read and then updated, and the result moves to
// the output register, after which the input is free again. A successful
// allocate that leaves free pages adds a rescan of the map memory, one 64-bit
// word read per cycle, before the result moves on. The single read port sets
// that rate. After reset the map is cleared one word per cycle (WORDS words, 64
// by default) with req_stall high. A waiting result does not block acceptance
// of the next transaction; it only holds the finish of that one.
module bitmap_page_allocator
   import bpa_pkg::*;
#(
   parameter int unsigned MAP_BYTES = DEF_MAP_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [PAGE_IDX_W-1:0] req_page_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_ok,
   output logic [GRANT_W-1:0]    rsp_granted_page
);

   bpa_cmd_type    cmd;
   bpa_status_type status;

   // sequencing: clear pass, accept, read, update, rescan, hand-off
   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // map memory, used count, free hint and result registers
   bpa_datapath #(
      .MAP_BYTES (MAP_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_kind),
      .req_page_index   (req_page_index),
      .rsp_ok           (rsp_ok),
      .rsp_granted_page (rsp_granted_page)
   );

endmodule

### dv/bitmap_page_allocator_test.sv
// Self-checking testbench for the bitmap page allocator: a directed table, then random
// page traffic that grows and drains the map, all checked against a page-map predictor.
// Depends on rtl/bpa_pkg.sv and the bitmap_page_allocator top level.
module bitmap_page_allocator_test
   import bpa_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CLK_PERIOD     = 20;
   localparam int unsigned PAGE_COUNT     = DEF_MAP_BYTES * 8;
   localparam int unsigned LONG_HOLD      = 600;   // receiver hold-off, in cycles
   localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles with no transaction at all
   localparam int unsigned TAIL_CYCLES    = 100;   // settle time after the last result

   // Kind three has no name in the package; the block must treat it as a no-op.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic               ok;
      logic [GRANT_W-1:0] granted;
   } alloc_result_type;

   // One row of the directed table. When typed is set the expected result is the
   // one written in the row; otherwise the predictor supplies it.
   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [PAGE_IDX_W-1:0] page;
      logic                  typed;
      logic                  ok;
      logic [GRANT_W-1:0]    granted;
   } directed_row_type;

   // ------------------------------------------------------------------
   // DUT connections; every input has a known value from time zero.
   // ------------------------------------------------------------------
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_kind       = KIND_QUERY;
   logic [PAGE_IDX_W-1:0] req_page_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic                  rsp_ok;
   logic [GRANT_W-1:0]    rsp_granted_page;

   bitmap_page_allocator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_page_index   (req_page_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ok           (rsp_ok),
      .rsp_granted_page (rsp_granted_page)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor state: our own copy of the page map, the used count and
   // the hint for the next page to hand out.
   // ------------------------------------------------------------------
   bit                 page_taken [PAGE_COUNT];
   int unsigned        pages_in_use = 0;
   logic [GRANT_W-1:0] next_hint    = '0;

   alloc_result_type pending_results [$];   // expected results, oldest first
   int unsigned      error_count = 0;

   // Idle rates in percent per cycle, set per phase by the stimulus process.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // Stimulus bumps hold_token to ask the receiver for one long hold-off.
   int unsigned hold_token = 0;
   int unsigned hold_seen  = 0;
   int unsigned hold_left  = 0;

   int unsigned quiet_cycles = 0;

   // Lowest free page, scanning up from page 0.
   function automatic logic [GRANT_W-1:0] lowest_free_page();
      for (int p = 0; p < PAGE_COUNT; p++) begin
         if (!page_taken[p]) return GRANT_W'(p);
      end
      return next_hint;
   endfunction

   // Applies one accepted transaction to the page map and returns its result.
   function automatic alloc_result_type apply_page_request(input logic [KIND_W-1:0] kind,
                                                            input logic [PAGE_IDX_W-1:0] page);
      alloc_result_type res;
      res = '0;
      case (kind)
         KIND_ALLOC: begin
            if (pages_in_use < PAGE_COUNT) begin
               res.ok      = 1'b1;
               res.granted = next_hint;
               page_taken[next_hint] = 1'b1;
               pages_in_use++;
               // filling the last page leaves the hint on it, no rescan
               if (pages_in_use < PAGE_COUNT) next_hint = lowest_free_page();
            end
         end
         KIND_DEALLOC: begin
            if (page < PAGE_COUNT && page_taken[page]) begin
               page_taken[page] = 1'b0;
               // hint only moves when freeing out of a full map
               if (pages_in_use == PAGE_COUNT) next_hint = page[GRANT_W-1:0];
               pages_in_use--;
               res.ok = 1'b1;
            end
         end
         KIND_QUERY: res.ok = (page < PAGE_COUNT) && !page_taken[page];
         default: ;
      endcase
      return res;
   endfunction

   // A page that is currently allocated, from a random starting point.
   function automatic logic [PAGE_IDX_W-1:0] some_taken_page();
      int unsigned start;
      start = $urandom_range(PAGE_COUNT - 1);
      for (int i = 0; i < PAGE_COUNT; i++) begin
         if (page_taken[(start + i) % PAGE_COUNT])
            return PAGE_IDX_W'((start + i) % PAGE_COUNT);
      end
      return PAGE_IDX_W'(start);
   endfunction

   // Random transaction; percentages for allocate and deallocate, the rest mostly
   // queries with a sprinkle of the unused kind.
   task automatic pick_request(input int unsigned alloc_pct, input int unsigned dealloc_pct,
                               output logic [KIND_W-1:0] kind,
                               output logic [PAGE_IDX_W-1:0] page);
      int unsigned roll;
      int unsigned how;
      roll = $urandom_range(99);
      how  = $urandom_range(9);
      page = PAGE_IDX_W'($urandom_range(65535));   // page ignored by allocate: any value
      if (roll < alloc_pct) begin
         kind = KIND_ALLOC;
      end else if (roll < alloc_pct + dealloc_pct) begin
         kind = KIND_DEALLOC;
         if (how < 8 && pages_in_use > 0) page = some_taken_page();
         else if (how < 9) page = PAGE_IDX_W'($urandom_range(PAGE_COUNT - 1));
      end else if (roll < 98) begin
         kind = KIND_QUERY;
         if (how < 3 && pages_in_use > 0) page = some_taken_page();
         else if (how < 7) page = PAGE_IDX_W'($urandom_range(PAGE_COUNT - 1));
      end else begin
         kind = KIND_UNUSED;
      end
   endtask

   // Offers one transaction, waits for acceptance, then records its expectation.
   // Valid is only dropped when the sender chooses to idle, never on stall.
   task automatic issue_request(input logic [KIND_W-1:0] kind,
                                input logic [PAGE_IDX_W-1:0] page,
                                input logic typed = 1'b0,
                                input alloc_result_type typed_result = '0);
      alloc_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_page_index <= page;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_page_request(kind, page);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   // Sender goes quiet until every outstanding result has come back.
   task automatic await_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic random_burst(input int unsigned count, input int unsigned alloc_pct,
                               input int unsigned dealloc_pct);
      logic [KIND_W-1:0]     kind;
      logic [PAGE_IDX_W-1:0] page;
      repeat (count) begin
         pick_request(alloc_pct, dealloc_pct, kind, page);
         issue_request(kind, page);
      end
   endtask

   // ------------------------------------------------------------------
   // Directed table. Typed rows are the ones readable at a glance: fresh
   // map, range edges, the unused kind, first grants; the rest (hint not
   // following a free into a non-full map) go through the predictor.
   // ------------------------------------------------------------------
   directed_row_type directed_rows [24] = '{
      '{KIND_QUERY,   16'd0,     1'b1, 1'b1, 12'd0},   // fresh map: page 0 free
      '{KIND_QUERY,   16'd4095,  1'b1, 1'b1, 12'd0},   // last page free
      '{KIND_QUERY,   16'd4096,  1'b1, 1'b0, 12'd0},   // first page out of range
      '{KIND_QUERY,   16'hFFFF,  1'b1, 1'b0, 12'd0},
      '{KIND_DEALLOC, 16'd0,     1'b1, 1'b0, 12'd0},   // freeing a free page
      '{KIND_DEALLOC, 16'd4096,  1'b1, 1'b0, 12'd0},   // freeing out of range
      '{KIND_DEALLOC, 16'hFFFF,  1'b1, 1'b0, 12'd0},
      '{KIND_UNUSED,  16'hFFFF,  1'b1, 1'b0, 12'd0},   // unused kind: no effect
      '{KIND_ALLOC,   16'hFFFF,  1'b1, 1'b1, 12'd0},   // first grant is page 0
      '{KIND_ALLOC,   16'h0000,  1'b1, 1'b1, 12'd1},
      '{KIND_ALLOC,   16'hAAAA,  1'b1, 1'b1, 12'd2},
      '{KIND_QUERY,   16'd1,     1'b1, 1'b0, 12'd0},
      '{KIND_DEALLOC, 16'd1,     1'b1, 1'b1, 12'd0},
      '{KIND_QUERY,   16'd1,     1'b1, 1'b1, 12'd0},
      '{KIND_ALLOC,   16'h5555,  1'b0, 1'b0, 12'd0},   // hint was not moved by the free
      '{KIND_ALLOC,   16'h0000,  1'b0, 1'b0, 12'd0},   // rescan now picks the hole
      '{KIND_QUERY,   16'h5555,  1'b1, 1'b0, 12'd0},
      '{KIND_DEALLOC, 16'd0,     1'b1, 1'b1, 12'd0},
      '{KIND_DEALLOC, 16'd0,     1'b1, 1'b0, 12'd0},   // double free
      '{KIND_QUERY,   16'hAAAA,  1'b1, 1'b0, 12'd0},
      '{KIND_UNUSED,  16'h0000,  1'b1, 1'b0, 12'd0},
      '{KIND_ALLOC,   16'h0FFF,  1'b0, 1'b0, 12'd0},
      '{KIND_DEALLOC, 16'd4095,  1'b1, 1'b0, 12'd0},   // top page never allocated
      '{KIND_QUERY,   16'd4095,  1'b1, 1'b1, 12'd0}
   };

   // ------------------------------------------------------------------
   // Stimulus: reset, directed table, then three random phases.
   // ------------------------------------------------------------------
   initial begin : stimulus
      alloc_result_type typed_result;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // phase 1: sender idles lightly, receiver heavily
      send_idle_pct = 22;
      recv_idle_pct = 84;
      foreach (directed_rows[i]) begin
         typed_result = '{ok: directed_rows[i].ok, granted: directed_rows[i].granted};
         issue_request(directed_rows[i].kind, directed_rows[i].page,
                       directed_rows[i].typed, typed_result);
      end
      random_burst(600, 55, 25);
      await_all_results();

      // phase 2: roles swapped. Allocation-heavy traffic pushes the rescan
      // deeper into the map, then churn frees and refills scattered holes.
      send_idle_pct = 84;
      recv_idle_pct = 22;
      random_burst(600, 85, 5);
      random_burst(300, 45, 40);
      await_all_results();

      // phase 3: no idling. Receiver holds off for a long stretch while the
      // sender keeps offering, so the block backs up and stalls its input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_token <= hold_token + 1;
      random_burst(250, 10, 75);
      random_burst(250, 40, 35);
      await_all_results();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Result side: check each accepted transaction against the oldest
   // expectation, then decide the stall for the next cycle.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : result_side
      alloc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("rsp transaction with nothing expected: ok %0d granted_page %0d",
                   rsp_ok, rsp_granted_page);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ok !== want.ok) begin
               $error("rsp_ok mismatch: expected %0d, actual %0d", want.ok, rsp_ok);
               error_count++;
            end
            if (rsp_granted_page !== want.granted) begin
               $error("rsp_granted_page mismatch: expected %0d, actual %0d",
                      want.granted, rsp_granted_page);
               error_count++;
            end
         end
      end

      // long hold-off counted here, independent of the sender
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog: too long without any transaction on either channel means a hang.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

### sim.f
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_ctrl.sv
rtl/bpa_datapath.sv
rtl/bitmap_page_allocator.sv
dv/bitmap_page_allocator_test.sv
